@@ rtl/pst_pkg.sv @@
// ----------------------------------------------------------------------------
// Predecessor score table package
// Shared sizes, status codes and the running-best record type.
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned SCORE_W  = 16;
  localparam int unsigned ID_W     = 31;
  localparam int unsigned STATUS_W = 2;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED  = 2'd0,
    ST_FULL   = 2'd1,
    ST_FOUND  = 2'd2,
    ST_NOBODY = 2'd3
  } status_t;

  typedef struct packed {
    logic               have;
    logic [SCORE_W-1:0] score;
    logic [ID_W-1:0]    id;
  } best_t;

endpackage

@@ rtl/pst_cmp.sv @@
// ----------------------------------------------------------------------------
// Predecessor score table compare unit
// Decides whether one stored record replaces the running best for a query.
// ----------------------------------------------------------------------------
module pst_cmp (
  input  logic [pst_pkg::SCORE_W-1:0] key_i,
  input  logic [pst_pkg::SCORE_W-1:0] cand_score_i,
  input  logic [pst_pkg::ID_W-1:0]    cand_id_i,
  input  pst_pkg::best_t              best_i,
  output pst_pkg::best_t              best_o
);

  logic below;
  logic better;

  always_comb begin
    below  = cand_score_i < key_i;
    // A higher score wins; on an equal score the larger id wins.
    better = !best_i.have || (cand_score_i > best_i.score) ||
             ((cand_score_i == best_i.score) && (cand_id_i > best_i.id));
    if (below && better) begin
      best_o.have  = 1'b1;
      best_o.score = cand_score_i;
      best_o.id    = cand_id_i;
    end else begin
      best_o = best_i;
    end
  end

endmodule

@@ rtl/predecessor_score_table_unit.sv @@
// ----------------------------------------------------------------------------
// Predecessor score table
// Stores (score, id) records and answers strict-predecessor queries by a
// sequential scan of the record memory through one read port.
// ----------------------------------------------------------------------------
// Sequence: an add goes from acceptance to S_FIN and then to the registered
// result; a query scans the entries one at a time (S_SCAN) through the single
// memory read port and the compare unit, then passes S_DRAIN and S_FIN; on an
// empty table it goes straight to S_FIN. S_FIN waits while a result is held.
// Throughput: one word at a time; the input is ready only in S_IDLE.
// Reset: synchronous, active low; clears the record count and control state,
// the record memory itself is left as it is and needs no clearing pass.
module predecessor_score_table_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_command,
  input  logic [pst_pkg::SCORE_W-1:0]  in_score_key,
  input  logic [pst_pkg::ID_W-1:0]     in_record_id,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pst_pkg::STATUS_W-1:0] out_status,
  output logic [pst_pkg::SCORE_W-1:0]  out_found_score,
  output logic [pst_pkg::ID_W-1:0]     out_found_id
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FIN
  } state_t;

  localparam int unsigned REC_W = pst_pkg::SCORE_W + pst_pkg::ID_W;

  logic [REC_W-1:0] mem [pst_pkg::CAPACITY];
  logic [REC_W-1:0] rd_data_r;
  logic             mem_we;

  state_t                       state_r,     state_nxt;
  logic [pst_pkg::CNT_W-1:0]    count_r,     count_nxt;
  logic [pst_pkg::ADDR_W-1:0]   addr_r,      addr_nxt;
  logic                         rd_vld_r,    rd_vld_nxt;
  logic [pst_pkg::SCORE_W-1:0]  key_r,       key_nxt;
  logic                         query_r,     query_nxt;
  pst_pkg::status_t             add_st_r,    add_st_nxt;
  pst_pkg::best_t               best_r,      best_nxt;
  logic                         out_valid_r, out_valid_nxt;
  pst_pkg::status_t             out_st_r,    out_st_nxt;
  logic [pst_pkg::SCORE_W-1:0]  out_score_r, out_score_nxt;
  logic [pst_pkg::ID_W-1:0]     out_id_r,    out_id_nxt;

  pst_pkg::best_t cmp_best;
  logic           scan_last;
  logic           table_full;

  pst_cmp u_cmp (
    .key_i        (key_r),
    .cand_score_i (rd_data_r[REC_W-1:pst_pkg::ID_W]),
    .cand_id_i    (rd_data_r[pst_pkg::ID_W-1:0]),
    .best_i       (best_r),
    .best_o       (cmp_best)
  );

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_st_r;
  assign out_found_score = out_score_r;
  assign out_found_id    = out_id_r;

  assign table_full = (count_r == pst_pkg::CNT_W'(pst_pkg::CAPACITY));
  assign scan_last  = (pst_pkg::CNT_W'(addr_r) == (count_r - pst_pkg::CNT_W'(1)));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    addr_nxt      = addr_r;
    rd_vld_nxt    = 1'b0;
    key_nxt       = key_r;
    query_nxt     = query_r;
    add_st_nxt    = add_st_r;
    best_nxt      = best_r;
    out_valid_nxt = out_valid_r;
    out_st_nxt    = out_st_r;
    out_score_nxt = out_score_r;
    out_id_nxt    = out_id_r;
    mem_we        = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // The record read in the previous cycle meets the running best here.
    if (rd_vld_r) begin
      best_nxt = cmp_best;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          query_nxt = (in_command == pst_pkg::CMD_QUERY);
          if (in_command == pst_pkg::CMD_ADD) begin
            if (table_full) begin
              add_st_nxt = pst_pkg::ST_FULL;
            end else begin
              add_st_nxt = pst_pkg::ST_ADDED;
              mem_we     = 1'b1;
              count_nxt  = count_r + pst_pkg::CNT_W'(1);
            end
            state_nxt = S_FIN;
          end else begin
            key_nxt  = in_score_key;
            best_nxt = '0;
            addr_nxt = '0;
            if (count_r == '0) begin
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        rd_vld_nxt = 1'b1;
        if (scan_last) begin
          state_nxt = S_DRAIN;
        end else begin
          addr_nxt = addr_r + pst_pkg::ADDR_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_score_nxt = '0;
          out_id_nxt    = '0;
          if (!query_r) begin
            out_st_nxt = add_st_r;
          end else if (best_r.have) begin
            out_st_nxt    = pst_pkg::ST_FOUND;
            out_score_nxt = best_r.score;
            out_id_nxt    = best_r.id;
          end else begin
            out_st_nxt = pst_pkg::ST_NOBODY;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    addr_r      <= addr_nxt;
    key_r       <= key_nxt;
    query_r     <= query_nxt;
    add_st_r    <= add_st_nxt;
    best_r      <= best_nxt;
    out_st_r    <= out_st_nxt;
    out_score_r <= out_score_nxt;
    out_id_r    <= out_id_nxt;
  end

  // Record memory: one write port for adds, one registered read port for scans.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[pst_pkg::ADDR_W-1:0]] <= {in_score_key, in_record_id};
    end
    rd_data_r <= mem[addr_r];
  end

endmodule
